// ----- hdl/av_timestamp_mix_queue_macros.svh -----
// Assertion helpers used by the checker of this block.
`ifndef AV_TIMESTAMP_MIX_QUEUE_MACROS_SVH
`define AV_TIMESTAMP_MIX_QUEUE_MACROS_SVH

// Same-cycle implication.
`define AVTSMQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication.
`define AVTSMQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ----- hdl/avtsmq_pkg.sv -----
package avtsmq_pkg;

   localparam int TS_W        = 32;
   localparam int TAG_W       = 16;
   localparam int TDATA_W     = TS_W + TAG_W;
   localparam int ENTRY_W     = TS_W + 1 + TAG_W;
   localparam int RSP_TUSER_W = 2;
   localparam int KIND_BIT    = 0;
   localparam int OVF_BIT     = 1;

   localparam logic [3:0] THRESHOLD_RESET   = 4'd10;
   localparam logic       CSR_MIX_THRESHOLD = 1'b0;

   typedef struct packed {
      logic [TS_W-1:0]  stamp;
      logic             kind;
      logic [TAG_W-1:0] handle;
   } entry_type;

endpackage

// ----- hdl/avtsmq_ram.sv -----
module avtsmq_ram #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/av_timestamp_mix_queue.sv -----
// Timestamp-ordered audio/video mixing queue. Each req beat carries one message
// (timestamp and tag in tdata, video flag in tuser); it is inserted into a
// DEPTH-entry store kept sorted by timestamp, equal timestamps in arrival
// order, and the earliest entry may then be released on rsp according to the
// audio/video counts and mix_threshold. A beat arriving at a full store is
// dropped and answered with an overflow beat. The store is a circular buffer
// in one RAM with a registered read port; the insert walks backward from the
// tail one entry per cycle, reading the next entry while writing the previous
// one up a slot, then writes the new beat into its place and decides whether
// to release the earliest entry. A new beat is taken only when the previous
// one is done, while a released beat may still wait on rsp. No clearing pass
// after reset.
module av_timestamp_mix_queue
   import avtsmq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [TDATA_W-1:0]     req_tdata,   // timestamp, tag
   input  logic [0:0]             req_tuser,   // is_video
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [TDATA_W-1:0]     rsp_tdata,   // out_timestamp, out_tag
   output logic [RSP_TUSER_W-1:0] rsp_tuser,   // out_is_video, overflow
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int TW = (CW > 4) ? CW : 4;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_PLACE  = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] k);
      logic [SW-1:0] s;
      s = SW'(head) + SW'(k);
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   logic [2:0]             state_ff, state_in;
   logic [AW-1:0]          head_ff, head_in;
   logic [CW-1:0]          occ_ff, occ_in;
   logic [CW-1:0]          vcnt_ff, vcnt_in;
   logic [CW-1:0]          acnt_ff, acnt_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [3:0]             thr_ff, thr_in;
   logic                   ovf_ff, ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TS_W-1:0]        ts_ff, ts_in;
   logic                   vid_ff, vid_in;
   logic [TAG_W-1:0]       tag_ff, tag_in;
   logic [TDATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                   wr_en, rd_en, place_new, release_ok, req_beat, csr_write;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [ENTRY_W-1:0]     wr_data, rd_data;
   entry_type              new_entry, rd_entry;
   logic [TW-1:0]          vcnt_w, acnt_w, thr_w;

   avtsmq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign new_entry = '{stamp: ts_ff, kind: vid_ff, handle: tag_ff};
   assign rd_entry  = entry_type'(rd_data);
   assign vcnt_w    = TW'(vcnt_ff);
   assign acnt_w    = TW'(acnt_ff);
   assign thr_w     = TW'(thr_ff);
   assign release_ok = (vcnt_w >= thr_w && acnt_w == '0) ||
                       (acnt_w > thr_w && vcnt_w == '0) ||
                       (vcnt_w != '0 && acnt_w != '0);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_MIX_THRESHOLD) ? {28'd0, thr_ff} : 32'd0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      occ_in       = occ_ff;
      vcnt_in      = vcnt_ff;
      acnt_in      = acnt_ff;
      idx_in       = idx_ff;
      thr_in       = thr_ff;
      ovf_in       = ovf_ff;
      ts_in        = ts_ff;
      vid_in       = vid_ff;
      tag_in       = tag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      wr_en        = 1'b0;
      wr_addr      = phys(head_ff, idx_ff);
      wr_data      = new_entry;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      place_new    = 1'b0;

      if (csr_write && csr_paddr[2] == CSR_MIX_THRESHOLD) begin
         thr_in = csr_pwdata[3:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               ts_in  = req_tdata[TS_W-1:0];
               tag_in = req_tdata[TDATA_W-1:TS_W];
               vid_in = req_tuser[0];
               if (occ_ff == CW'(DEPTH)) begin
                  ovf_in   = 1'b1;
                  state_in = ST_EMIT;
               end else if (occ_ff == '0) begin
                  ovf_in   = 1'b0;
                  idx_in   = '0;
                  state_in = ST_PLACE;
               end else begin
                  ovf_in   = 1'b0;
                  rd_en    = 1'b1;
                  rd_addr  = phys(head_ff, occ_ff - CW'(1));
                  idx_in   = occ_ff;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_entry.stamp > ts_ff) begin
               wr_en   = 1'b1;
               wr_data = rd_data;
               if (idx_ff == CW'(1)) begin
                  idx_in   = '0;
                  state_in = ST_PLACE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = phys(head_ff, idx_ff - CW'(2));
                  idx_in  = idx_ff - CW'(1);
               end
            end else begin
               place_new = 1'b1;
            end
         end
         ST_PLACE: begin
            place_new = 1'b1;
         end
         ST_DECIDE: begin
            if (release_ok) begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (ovf_ff) begin
                  rsp_data_in = '0;
                  rsp_user_in = '0;
                  rsp_user_in[OVF_BIT] = 1'b1;
               end else begin
                  rsp_data_in = {rd_entry.handle, rd_entry.stamp};
                  rsp_user_in = '0;
                  rsp_user_in[KIND_BIT] = rd_entry.kind;
                  head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
                  occ_in  = occ_ff - CW'(1);
                  if (rd_entry.kind) begin
                     vcnt_in = vcnt_ff - CW'(1);
                  end else begin
                     acnt_in = acnt_ff - CW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (place_new) begin
         wr_en    = 1'b1;
         wr_addr  = phys(head_ff, idx_ff);
         wr_data  = new_entry;
         occ_in   = occ_ff + CW'(1);
         state_in = ST_DECIDE;
         if (vid_ff) begin
            vcnt_in = vcnt_ff + CW'(1);
         end else begin
            acnt_in = acnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         vcnt_ff      <= '0;
         acnt_ff      <= '0;
         idx_ff       <= '0;
         thr_ff       <= THRESHOLD_RESET;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         vcnt_ff      <= vcnt_in;
         acnt_ff      <= acnt_in;
         idx_ff       <= idx_in;
         thr_ff       <= thr_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ts_ff       <= ts_in;
      vid_ff      <= vid_in;
      tag_ff      <= tag_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

// ----- hdl/av_timestamp_mix_queue_checker.sv -----
`include "av_timestamp_mix_queue_macros.svh"

module av_timestamp_mix_queue_checker
   import avtsmq_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [TDATA_W-1:0]     rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser,
   input logic [31:0]            csr_prdata
);

   `AVTSMQ_ASSERT_NEXT(rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `AVTSMQ_ASSERT_NOW(ovf_beat_empty, clock, reset, rsp_tvalid && rsp_tuser[OVF_BIT], rsp_tdata == '0 && !rsp_tuser[KIND_BIT])
   `AVTSMQ_ASSERT_NEXT(busy_after_beat, clock, reset, req_tvalid && req_tready, !req_tready)
   `AVTSMQ_ASSERT_NOW(prdata_narrow, clock, reset, 1'b1, csr_prdata[31:4] == 28'd0)

endmodule

bind av_timestamp_mix_queue av_timestamp_mix_queue_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser),
   .csr_prdata(csr_prdata)
);
